>>> hw/rtl/urbp_pkg.sv
// Package with shared types and constants for the UART ring buffer pair.
`timescale 1ns / 1ps

package urbp_pkg;

  localparam logic [2:0] OP_RX_BYTE  = 3'd0;
  localparam logic [2:0] OP_TX_READY = 3'd1;
  localparam logic [2:0] OP_READ     = 3'd2;
  localparam logic [2:0] OP_SEND     = 3'd3;
  localparam logic [2:0] OP_QUEUE    = 3'd4;
  localparam logic [2:0] OP_START_TX = 3'd5;
  localparam logic [2:0] OP_FLUSH    = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TX_FULL  = 2'd1;
  localparam logic [1:0] ST_RX_OVF   = 2'd2;
  localparam logic [1:0] ST_RX_EMPTY = 2'd3;

  localparam logic [1:0] PH_NONE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  localparam logic [7:0] PREFIX_FIRST  = 8'h2F;
  localparam logic [7:0] PREFIX_SECOND = 8'h5C;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/uart_ring_buffer_pair.sv
// Top level of the UART receive/transmit ring buffer pair.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    in_op, in_data
//   out_     output     out_valid/out_stall  tx/read fields, status, ring flags
//   cfg_     input      cfg_we               cfg_prefix_enable
//
// Each transaction first does the registered ring read at the slot after each
// tail, then updates the pointers and loads the result register.
// One transaction is in flight at a time; a stalled result holds execution
// of the next one. Reset is synchronous, active low, and clears pointers,
// prefix phase, transmit enable and prefix_enable; no clearing pass.
`timescale 1ns / 1ps

module uart_ring_buffer_pair #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_data,
  input  logic       cfg_we,
  input  logic       cfg_prefix_enable,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_read_valid,
  output logic [7:0] out_read_data,
  output logic [1:0] out_status,
  output logic       out_rx_nonempty,
  output logic       out_tx_nonempty,
  output logic       out_tx_enabled
);

  urbp_pkg::cmd_t cmd;
  urbp_pkg::sts_t sts;

  urbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  urbp_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_data           (in_data),
    .cfg_we            (cfg_we),
    .cfg_prefix_enable (cfg_prefix_enable),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_valid      (out_tx_valid),
    .out_tx_byte       (out_tx_byte),
    .out_read_valid    (out_read_valid),
    .out_read_data     (out_read_data),
    .out_status        (out_status),
    .out_rx_nonempty   (out_rx_nonempty),
    .out_tx_nonempty   (out_tx_nonempty),
    .out_tx_enabled    (out_tx_enabled)
  );

endmodule

>>> hw/rtl/urbp_ctrl.sv
// Controller state machine: accepts a transaction, then schedules its execution.
`timescale 1ns / 1ps

module urbp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  urbp_pkg::sts_t sts,
  output urbp_pkg::cmd_t cmd
);

  urbp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= urbp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      urbp_pkg::S_IDLE: begin
        if (in_valid) state_nxt = urbp_pkg::S_EXEC;
      end
      urbp_pkg::S_EXEC: begin
        if (sts.out_free) state_nxt = urbp_pkg::S_IDLE;
      end
      default: state_nxt = urbp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      urbp_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      urbp_pkg::S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> hw/rtl/urbp_dp.sv
// Datapath: receive and transmit rings, pointers, prefix phase and result register.
`timescale 1ns / 1ps

module urbp_dp #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  urbp_pkg::cmd_t cmd,
  output urbp_pkg::sts_t sts,
  input  logic [2:0]     in_op,
  input  logic [7:0]     in_data,
  input  logic           cfg_we,
  input  logic           cfg_prefix_enable,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_tx_valid,
  output logic [7:0]     out_tx_byte,
  output logic           out_read_valid,
  output logic [7:0]     out_read_data,
  output logic [1:0]     out_status,
  output logic           out_rx_nonempty,
  output logic           out_tx_nonempty,
  output logic           out_tx_enabled
);

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RX_AW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [TX_AW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
  logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
  logic [1:0]       phase_r, phase_nxt;
  logic             irq_r, irq_nxt;
  logic             prefix_en_r;
  logic [2:0]       op_r;
  logic [7:0]       data_r;
  logic [7:0]       rx_rd_r, tx_rd_r;
  logic             rx_we, tx_we;

  logic             out_valid_r;
  logic             tx_valid_r, tx_valid_nxt;
  logic [7:0]       tx_byte_r, tx_byte_nxt;
  logic             read_valid_r, read_valid_nxt;
  logic [7:0]       read_data_r, read_data_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             rx_ne_r, tx_ne_r, tx_en_r;

  assign rx_head_inc = (rx_head_r == RX_LAST) ? '0 : rx_head_r + 1'b1;
  assign rx_tail_inc = (rx_tail_r == RX_LAST) ? '0 : rx_tail_r + 1'b1;
  assign tx_head_inc = (tx_head_r == TX_LAST) ? '0 : tx_head_r + 1'b1;
  assign tx_tail_inc = (tx_tail_r == TX_LAST) ? '0 : tx_tail_r + 1'b1;

  assign sts.out_free = !out_valid_r || !out_stall;

  // Operand capture and ring reads at the slot after each tail
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      data_r  <= in_data;
      rx_rd_r <= rx_mem[rx_tail_inc];
      tx_rd_r <= tx_mem[tx_tail_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_head_inc] <= data_r;
  end

  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_head_inc] <= data_r;
  end

  always_comb begin
    rx_head_nxt    = rx_head_r;
    rx_tail_nxt    = rx_tail_r;
    tx_head_nxt    = tx_head_r;
    tx_tail_nxt    = tx_tail_r;
    phase_nxt      = phase_r;
    irq_nxt        = irq_r;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    tx_valid_nxt   = 1'b0;
    tx_byte_nxt    = 8'h00;
    read_valid_nxt = 1'b0;
    read_data_nxt  = 8'h00;
    status_nxt     = urbp_pkg::ST_OK;
    unique case (op_r)
      urbp_pkg::OP_RX_BYTE: begin
        if (rx_head_inc == rx_tail_r) begin
          status_nxt = urbp_pkg::ST_RX_OVF;
        end else begin
          rx_head_nxt = rx_head_inc;
          rx_we       = cmd.exec;
        end
      end
      urbp_pkg::OP_TX_READY: begin
        if (irq_r) begin
          if (tx_head_r != tx_tail_r) begin
            tx_valid_nxt = 1'b1;
            if (prefix_en_r && phase_r == urbp_pkg::PH_NONE) begin
              phase_nxt   = urbp_pkg::PH_FIRST;
              tx_byte_nxt = urbp_pkg::PREFIX_FIRST;
            end else if (prefix_en_r && phase_r == urbp_pkg::PH_FIRST) begin
              phase_nxt   = urbp_pkg::PH_SECOND;
              tx_byte_nxt = urbp_pkg::PREFIX_SECOND;
            end else begin
              phase_nxt   = urbp_pkg::PH_NONE;
              tx_tail_nxt = tx_tail_inc;
              tx_byte_nxt = tx_rd_r;
            end
          end else begin
            irq_nxt = 1'b0;
          end
        end
      end
      urbp_pkg::OP_READ: begin
        if (rx_head_r == rx_tail_r) begin
          status_nxt = urbp_pkg::ST_RX_EMPTY;
        end else begin
          rx_tail_nxt    = rx_tail_inc;
          read_valid_nxt = 1'b1;
          read_data_nxt  = rx_rd_r;
        end
      end
      urbp_pkg::OP_SEND, urbp_pkg::OP_QUEUE: begin
        if (tx_head_inc == tx_tail_r) begin
          status_nxt = urbp_pkg::ST_TX_FULL;
        end else begin
          tx_head_nxt = tx_head_inc;
          tx_we       = cmd.exec;
          if (op_r == urbp_pkg::OP_SEND) irq_nxt = 1'b1;
        end
      end
      urbp_pkg::OP_START_TX: begin
        irq_nxt = 1'b1;
      end
      urbp_pkg::OP_FLUSH: begin
        rx_head_nxt = '0;
        rx_tail_nxt = '0;
        tx_head_nxt = '0;
        tx_tail_nxt = '0;
        phase_nxt   = urbp_pkg::PH_NONE;
        irq_nxt     = 1'b0;
      end
      default: begin
        status_nxt = urbp_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      phase_r     <= urbp_pkg::PH_NONE;
      irq_r       <= 1'b0;
      prefix_en_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) prefix_en_r <= cfg_prefix_enable;
      if (cmd.exec) begin
        rx_head_r   <= rx_head_nxt;
        rx_tail_r   <= rx_tail_nxt;
        tx_head_r   <= tx_head_nxt;
        tx_tail_r   <= tx_tail_nxt;
        phase_r     <= phase_nxt;
        irq_r       <= irq_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      tx_valid_r   <= tx_valid_nxt;
      tx_byte_r    <= tx_byte_nxt;
      read_valid_r <= read_valid_nxt;
      read_data_r  <= read_data_nxt;
      status_r     <= status_nxt;
      rx_ne_r      <= (rx_head_nxt != rx_tail_nxt);
      tx_ne_r      <= (tx_head_nxt != tx_tail_nxt);
      tx_en_r      <= irq_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tx_valid    = tx_valid_r;
  assign out_tx_byte     = tx_byte_r;
  assign out_read_valid  = read_valid_r;
  assign out_read_data   = read_data_r;
  assign out_status      = status_r;
  assign out_rx_nonempty = rx_ne_r;
  assign out_tx_nonempty = tx_ne_r;
  assign out_tx_enabled  = tx_en_r;

endmodule

>>> hw/rtl/urbp_checker.sv
// Port-level assertion checker for the UART ring buffer pair, with its bind.
`timescale 1ns / 1ps

module urbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_read_valid,
  input logic [1:0] out_status,
  input logic       out_rx_nonempty,
  input logic       out_tx_enabled
);

  // one transaction at a time
  a_single_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte))
    else $error("stalled result changed");

  a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |->
      out_status == urbp_pkg::ST_OK && !out_read_valid && out_tx_enabled)
    else $error("transmit result with bad status or flags");

  a_rx_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == urbp_pkg::ST_RX_EMPTY |->
      !out_read_valid && !out_rx_nonempty)
    else $error("empty read status inconsistent");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind uart_ring_buffer_pair urbp_checker u_urbp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_tx_valid    (out_tx_valid),
  .out_tx_byte     (out_tx_byte),
  .out_read_valid  (out_read_valid),
  .out_status      (out_status),
  .out_rx_nonempty (out_rx_nonempty),
  .out_tx_enabled  (out_tx_enabled)
);

>>> dv/uart_ring_buffer_pair_tb.sv
// Self-checking testbench for the UART receive/transmit ring buffer pair.
`timescale 1ns / 1ps

module uart_ring_buffer_pair_tb;

  localparam logic [2:0] OP_NONE = 3'd7;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int RING_SLOTS = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int OPS_PER_PHASE = 192;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
  } host_op_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic [1:0] status;
    logic       rx_nonempty;
    logic       tx_nonempty;
    logic       tx_enabled;
  } uart_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_op = OP_NONE;
  logic [7:0] in_data = 8'h00;
  logic       cfg_we = 1'b0;
  logic       cfg_prefix_enable = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_tx_valid;
  logic [7:0] out_tx_byte;
  logic       out_read_valid;
  logic [7:0] out_read_data;
  logic [1:0] out_status;
  logic       out_rx_nonempty;
  logic       out_tx_nonempty;
  logic       out_tx_enabled;

  host_op_t     host_line_ops[$];
  uart_result_t due_results[$];

  // predictor state
  logic [7:0] rx_mem[RING_SLOTS];
  logic [7:0] tx_mem[RING_SLOTS];
  logic [3:0] rx_wr, rx_rd, tx_wr, tx_rd;
  logic [1:0] pfx_phase;
  logic       tx_on;
  logic       prefix_on;

  bit gaps_on;
  bit stall_on;
  int gap_left;
  int stall_left;
  int hold_left;
  bit hold_done;
  int idle_cycles;
  int errors;
  int ops_sent;
  int results_seen;
  int n_tx_bytes, n_prefix_bytes, n_reads, n_ovf, n_tx_full, n_empty_reads, n_flush;

  uart_ring_buffer_pair dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_data          (in_data),
    .cfg_we           (cfg_we),
    .cfg_prefix_enable(cfg_prefix_enable),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_read_valid   (out_read_valid),
    .out_read_data    (out_read_data),
    .out_status       (out_status),
    .out_rx_nonempty  (out_rx_nonempty),
    .out_tx_nonempty  (out_tx_nonempty),
    .out_tx_enabled   (out_tx_enabled)
  );

  always #2 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic uart_result_t apply_uart_op(logic [2:0] op, logic [7:0] data);
    uart_result_t r;
    logic [3:0] nxt;
    r = '0;
    case (op)
      urbp_pkg::OP_RX_BYTE: begin
        nxt = rx_wr + 4'd1;
        if (nxt == rx_rd) begin
          r.status = urbp_pkg::ST_RX_OVF;
          n_ovf++;
        end else begin
          rx_wr = nxt;
          rx_mem[nxt] = data;
        end
      end
      urbp_pkg::OP_TX_READY: begin
        if (tx_on) begin
          if (tx_wr != tx_rd) begin
            r.tx_valid = 1'b1;
            if (prefix_on && pfx_phase == urbp_pkg::PH_NONE) begin
              pfx_phase = urbp_pkg::PH_FIRST;
              r.tx_byte = urbp_pkg::PREFIX_FIRST;
              n_prefix_bytes++;
            end else if (prefix_on && pfx_phase == urbp_pkg::PH_FIRST) begin
              pfx_phase = urbp_pkg::PH_SECOND;
              r.tx_byte = urbp_pkg::PREFIX_SECOND;
              n_prefix_bytes++;
            end else begin
              pfx_phase = urbp_pkg::PH_NONE;
              tx_rd = tx_rd + 4'd1;
              r.tx_byte = tx_mem[tx_rd];
              n_tx_bytes++;
            end
          end else begin
            tx_on = 1'b0;
          end
        end
      end
      urbp_pkg::OP_READ: begin
        if (rx_wr == rx_rd) begin
          r.status = urbp_pkg::ST_RX_EMPTY;
          n_empty_reads++;
        end else begin
          rx_rd = rx_rd + 4'd1;
          r.read_valid = 1'b1;
          r.read_data = rx_mem[rx_rd];
          n_reads++;
        end
      end
      urbp_pkg::OP_SEND, urbp_pkg::OP_QUEUE: begin
        nxt = tx_wr + 4'd1;
        if (nxt == tx_rd) begin
          r.status = urbp_pkg::ST_TX_FULL;
          n_tx_full++;
        end else begin
          tx_mem[nxt] = data;
          tx_wr = nxt;
          if (op == urbp_pkg::OP_SEND) tx_on = 1'b1;
        end
      end
      urbp_pkg::OP_START_TX: tx_on = 1'b1;
      urbp_pkg::OP_FLUSH: begin
        rx_wr = '0;
        rx_rd = '0;
        tx_wr = '0;
        tx_rd = '0;
        pfx_phase = urbp_pkg::PH_NONE;
        tx_on = 1'b0;
        n_flush++;
      end
      default: ;
    endcase
    r.rx_nonempty = (rx_wr != rx_rd);
    r.tx_nonempty = (tx_wr != tx_rd);
    r.tx_enabled = tx_on;
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_uart_op(in_op, in_data));
        void'(host_line_ops.pop_front());
        ops_sent++;
        offer = 1'b0;
        gap_left = (gaps_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (host_line_ops.size() != 0) begin
          in_valid <= 1'b1;
          in_op <= host_line_ops[0].op;
          in_data <= host_line_ops[0].data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall generator, including one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    uart_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tx %0b/0x%0h read %0b/0x%0h",
                 $time, out_tx_valid, out_tx_byte, out_read_valid, out_read_data);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("tx_valid", 8'(want.tx_valid), 8'(out_tx_valid));
        check_field("tx_byte", want.tx_byte, out_tx_byte);
        check_field("read_valid", 8'(want.read_valid), 8'(out_read_valid));
        check_field("read_data", want.read_data, out_read_data);
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("rx_nonempty", 8'(want.rx_nonempty), 8'(out_rx_nonempty));
        check_field("tx_nonempty", 8'(want.tx_nonempty), 8'(out_tx_nonempty));
        check_field("tx_enabled", 8'(want.tx_enabled), 8'(out_tx_enabled));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, due_results.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_op(logic [2:0] op, logic [7:0] data);
    host_op_t t;
    t.op = op;
    t.data = data;
    host_line_ops.push_back(t);
  endtask

  task automatic wait_idle();
    while (host_line_ops.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_prefix(bit v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_prefix_enable <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    prefix_on = v;
    @(negedge clk);
  endtask

  // bursts of like operations, plus single random ops and flushes, so both rings run full and empty
  task automatic queue_random_ops(int count);
    int added, n, kind;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 22) begin
        n = $urandom_range(1, 20);
        repeat (n) push_op(urbp_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)));
      end else if (kind < 40) begin
        n = $urandom_range(1, 20);
        repeat (n) push_op(urbp_pkg::OP_READ, 8'($urandom_range(0, 255)));
      end else if (kind < 60) begin
        n = $urandom_range(1, 18);
        repeat (n)
          push_op(($urandom_range(0, 3) == 0) ? urbp_pkg::OP_QUEUE : urbp_pkg::OP_SEND,
                  8'($urandom_range(0, 255)));
      end else if (kind < 82) begin
        n = $urandom_range(1, 50);
        if ($urandom_range(0, 1) == 1) begin
          push_op(urbp_pkg::OP_START_TX, 8'($urandom_range(0, 255)));
          added++;
        end
        repeat (n) push_op(urbp_pkg::OP_TX_READY, 8'($urandom_range(0, 255)));
      end else if (kind < 96) begin
        n = 1;
        push_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else begin
        n = 1;
        push_op(urbp_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
      end
      added += n;
    end
  endtask

  initial begin
    bit pfx_plan[RANDOM_PHASES];
    pfx_plan = '{1, 0, 1, 1, 0, 0, 1, 0};
    for (int i = 0; i < RING_SLOTS; i++) begin
      rx_mem[i] = '0;
      tx_mem[i] = '0;
    end
    rx_wr = '0;
    rx_rd = '0;
    tx_wr = '0;
    tx_rd = '0;
    pfx_phase = urbp_pkg::PH_NONE;
    tx_on = 1'b0;
    prefix_on = 1'b0;
    gaps_on = 1'b0;
    stall_on = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: empty reads, disabled/empty transmitter, byte extremes, flush
    set_prefix(1'b0);
    push_op(urbp_pkg::OP_READ, 8'h00);
    push_op(urbp_pkg::OP_TX_READY, 8'hFF);
    push_op(urbp_pkg::OP_START_TX, 8'h00);
    push_op(urbp_pkg::OP_TX_READY, 8'h00);
    push_op(urbp_pkg::OP_RX_BYTE, 8'h00);
    push_op(urbp_pkg::OP_RX_BYTE, 8'hFF);
    push_op(urbp_pkg::OP_READ, 8'h00);
    push_op(urbp_pkg::OP_READ, 8'h00);
    push_op(urbp_pkg::OP_QUEUE, 8'hFF);
    push_op(urbp_pkg::OP_TX_READY, 8'h00);
    push_op(urbp_pkg::OP_SEND, 8'h00);
    push_op(urbp_pkg::OP_TX_READY, 8'h00);
    push_op(urbp_pkg::OP_TX_READY, 8'h00);
    push_op(urbp_pkg::OP_TX_READY, 8'h00);
    push_op(OP_NONE, 8'hA5);
    push_op(urbp_pkg::OP_RX_BYTE, 8'h5A);
    push_op(urbp_pkg::OP_FLUSH, 8'hFF);
    push_op(urbp_pkg::OP_READ, 8'h00);
    wait_idle();

    // directed: prefixed transmit
    set_prefix(1'b1);
    push_op(urbp_pkg::OP_SEND, 8'h81);
    repeat (4) push_op(urbp_pkg::OP_TX_READY, 8'h00);
    push_op(OP_NONE, 8'hFF);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_prefix(pfx_plan[p]);
      gaps_on = (p % 4) != 0;
      stall_on = (p % 4) != 0;
      queue_random_ops(OPS_PER_PHASE);
      wait_idle();
    end

    $display("Covered %0d transactions, %0d results checked; %0d data, %0d prefix bytes sent,",
             ops_sent, results_seen, n_tx_bytes, n_prefix_bytes);
    $display("  %0d host reads, %0d empty reads, %0d rx overflows, %0d tx-full drops, %0d flushes",
             n_reads, n_empty_reads, n_ovf, n_tx_full, n_flush);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
